[design/rpn_pkg.sv]
// Shared constants and types for the RPN character evaluator.
// Used by rpn_alu and rpn_char_evaluator_top; depends on nothing.
`default_nettype none

package rpn_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned STACK_DEPTH_DEF = 128;

  // character codes
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;
  localparam logic [CHAR_W-1:0] CH_STAR    = 8'd42;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'd45;
  localparam logic [CHAR_W-1:0] CH_SLASH   = 8'd47;
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'd57;
  localparam logic [CHAR_W-1:0] CH_EQUALS  = 8'd61;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_DIVZERO   = 3'd3,
    ST_EQUALS    = 3'd4,
    ST_OTHER     = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

`default_nettype wire

[design/rpn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the lower entries of the value stack.
`default_nettype none

module rpn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/rpn_alu.sv]
// Bit-serial arithmetic unit: add, subtract, multiply, truncating divide.
// One bit of the operands per cycle; uses rpn_pkg.
`default_nettype none

module rpn_alu (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire rpn_pkg::alu_req_t              req_i,
  input  wire logic [rpn_pkg::WORD_W-1:0]     a_i,
  input  wire logic [rpn_pkg::WORD_W-1:0]     b_i,
  output rpn_pkg::alu_sts_t                   sts_o,
  output logic      [rpn_pkg::WORD_W-1:0]     res_o
);

  localparam int unsigned W     = rpn_pkg::WORD_W;
  localparam int unsigned CNT_W = $clog2(W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  rpn_pkg::op_e     op_q;
  logic [W-1:0]     a_q;
  logic [W-1:0]     b_q;
  logic [W-1:0]     acc_q;
  logic             carry_q;
  logic             neg_q;
  logic [W-1:0]     res_q;
  logic             done_q;

  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;
  logic         b_bit;
  logic         sum_bit;
  logic         carry_n;
  logic [W-1:0] mul_sum;
  logic [W:0]   rem_sh;
  logic [W:0]   rem_diff;
  logic         q_bit;
  logic [W-1:0] rem_next;

  assign a_mag = a_i[W-1] ? (W'(0) - a_i) : a_i;
  assign b_mag = b_i[W-1] ? (W'(0) - b_i) : b_i;

  // serial add / subtract: one sum bit a cycle, shifted in from the top
  assign b_bit   = (op_q == rpn_pkg::OP_SUB) ? ~b_q[0] : b_q[0];
  assign sum_bit = a_q[0] ^ b_bit ^ carry_q;
  assign carry_n = (a_q[0] & b_bit) | (a_q[0] & carry_q) | (b_bit & carry_q);

  // shift-and-add multiply, low word only
  assign mul_sum = acc_q + (b_q[0] ? a_q : W'(0));

  // restoring divide on magnitudes; a_q shifts dividend out, quotient in
  assign rem_sh   = {acc_q, a_q[W-1]};
  assign rem_diff = rem_sh - {1'b0, b_q};
  assign q_bit    = ~rem_diff[W];
  assign rem_next = q_bit ? rem_diff[W-1:0] : rem_sh[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            op_q    <= req_i.op;
            cnt_q   <= '0;
            acc_q   <= '0;
            carry_q <= (req_i.op == rpn_pkg::OP_SUB);
            neg_q   <= a_i[W-1] ^ b_i[W-1];
            if (req_i.op == rpn_pkg::OP_DIV) begin
              a_q <= a_mag;
              b_q <= b_mag;
            end else begin
              a_q <= a_i;
              b_q <= b_i;
            end
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          case (op_q)
            rpn_pkg::OP_ADD, rpn_pkg::OP_SUB: begin
              a_q     <= a_q >> 1;
              b_q     <= b_q >> 1;
              acc_q   <= {sum_bit, acc_q[W-1:1]};
              carry_q <= carry_n;
            end
            rpn_pkg::OP_MUL: begin
              acc_q <= mul_sum;
              a_q   <= a_q << 1;
              b_q   <= b_q >> 1;
            end
            rpn_pkg::OP_DIV: begin
              acc_q <= rem_next;
              a_q   <= {a_q[W-2:0], q_bit};
            end
            default: begin
            end
          endcase
          cnt_q <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (op_q == rpn_pkg::OP_DIV) begin
            res_q <= neg_q ? (W'(0) - a_q) : a_q;
          end else begin
            res_q <= acc_q;
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign sts_o.busy = (state_q != S_IDLE);
  assign sts_o.done = done_q;
  assign res_o      = res_q;

endmodule

`default_nettype wire

[design/rpn_char_evaluator_top.sv]
// Reverse Polish notation evaluator, one character per transaction.
// Top level: control sequencer over rpn_ram and rpn_alu; uses rpn_pkg.
//
// Feed one ASCII character per input transaction. Digits push their value,
// + - * / pop two values and push the result (32-bit wrapping arithmetic,
// division truncating toward zero), spaces are skipped, and a newline
// produces one output transaction carrying the line status, the top of the
// stack (zero when empty) and an empty flag, then clears the stack. After
// the first error or stop character the rest of the line is ignored until
// the newline. An operator stalls the input until it is done: it is
// accepted, the left operand is read from the stack RAM and loaded into
// the bit-serial arithmetic unit, which runs WORD_W bit steps and a
// finish step, and the result is written back to the top of stack. A
// divide by zero instead drops both operands, refilling the top from the
// RAM when a third entry lies below. The top of stack lives in a register
// and the lower entries in a single-port-read RAM, so each operator costs
// one RAM read, plus one more to refill the top after a divide by zero. A
// result waiting at the output does not block further characters, only
// the next newline.
`default_nettype none

module rpn_char_evaluator_top #(
  parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [rpn_pkg::CHAR_W-1:0]     char_code_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [2:0]                     status_o,
  output logic signed [rpn_pkg::WORD_W-1:0]   top_value_o,
  output logic                                stack_empty_o
);

  localparam int unsigned W  = rpn_pkg::WORD_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ALU,
    S_POP
  } state_e;

  state_e            state_q;
  logic [DW-1:0]     depth_q;
  rpn_pkg::status_e  status_q;
  logic [W-1:0]      top_q;
  rpn_pkg::op_e      op_q;

  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [W-1:0]      out_top_q;
  logic              out_empty_q;

  logic              accept;
  logic              is_newline;
  logic              is_digit;
  logic              is_op;
  rpn_pkg::op_e      op_dec;
  logic              line_ok;
  logic              depth_full;
  logic              depth_ge2;
  logic              depth_ge3;
  logic [DW-1:0]     depth_m1;
  logic [DW-1:0]     depth_m2;
  logic [DW-1:0]     depth_m3;
  logic              div_zero;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [W-1:0]      ram_rdata;

  rpn_pkg::alu_req_t alu_req;
  rpn_pkg::alu_sts_t alu_sts;
  logic [W-1:0]      alu_res;

  // ---------------------------------------------------------------------
  // Character decode
  // ---------------------------------------------------------------------
  assign is_newline = (char_code_i == rpn_pkg::CH_NEWLINE);
  assign is_digit   = (char_code_i >= rpn_pkg::CH_ZERO) &&
                      (char_code_i <= rpn_pkg::CH_NINE);
  assign is_op      = (char_code_i == rpn_pkg::CH_PLUS)  ||
                      (char_code_i == rpn_pkg::CH_MINUS) ||
                      (char_code_i == rpn_pkg::CH_STAR)  ||
                      (char_code_i == rpn_pkg::CH_SLASH);

  always_comb begin
    op_dec = rpn_pkg::OP_ADD;
    if (char_code_i == rpn_pkg::CH_MINUS) begin
      op_dec = rpn_pkg::OP_SUB;
    end else if (char_code_i == rpn_pkg::CH_STAR) begin
      op_dec = rpn_pkg::OP_MUL;
    end else if (char_code_i == rpn_pkg::CH_SLASH) begin
      op_dec = rpn_pkg::OP_DIV;
    end
  end

  // Hold off everything while an operator is in flight; hold off only a
  // newline while the previous line's result is still waiting.
  assign in_stall_o = (state_q != S_IDLE) ||
                      (out_valid_q && out_stall_i && is_newline);
  assign accept     = in_valid_i && !in_stall_o;

  assign line_ok    = (status_q == rpn_pkg::ST_OK);
  assign depth_full = (depth_q >= DW'(STACK_DEPTH));
  assign depth_ge2  = (depth_q >= DW'(2));
  assign depth_ge3  = (depth_q >= DW'(3));
  assign depth_m1   = depth_q - DW'(1);
  assign depth_m2   = depth_q - DW'(2);
  assign depth_m3   = depth_q - DW'(3);
  assign div_zero   = (op_q == rpn_pkg::OP_DIV) && (top_q == W'(0));

  // ---------------------------------------------------------------------
  // Stack RAM: entries below the top; the top itself sits in top_q
  // ---------------------------------------------------------------------
  // Spill the old top into the RAM when a digit is pushed.
  assign ram_we    = accept && !is_newline && line_ok && is_digit &&
                     !depth_full && (depth_q != DW'(0));
  assign ram_waddr = depth_m1[AW-1:0];

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = depth_m2[AW-1:0];
    if (state_q == S_IDLE) begin
      // fetch the left operand
      ram_re    = accept && !is_newline && line_ok && is_op && depth_ge2;
      ram_raddr = depth_m2[AW-1:0];
    end else if (state_q == S_READ) begin
      // divide by zero drops both operands: refill the top from below
      ram_re    = div_zero && depth_ge3;
      ram_raddr = depth_m3[AW-1:0];
    end
  end

  rpn_ram #(
    .WIDTH (W),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (top_q),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------
  // Serial arithmetic unit
  // ---------------------------------------------------------------------
  assign alu_req.start = (state_q == S_READ) && !div_zero;
  assign alu_req.op    = op_q;

  rpn_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (ram_rdata),
    .b_i    (top_q),
    .sts_o  (alu_sts),
    .res_o  (alu_res)
  );

  // ---------------------------------------------------------------------
  // Sequencer and result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      status_q    <= rpn_pkg::ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      // drop the result once it has been taken
      if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (accept) begin
            if (is_newline) begin
              out_valid_q  <= 1'b1;
              out_status_q <= status_q;
              out_top_q    <= (depth_q == DW'(0)) ? W'(0) : top_q;
              out_empty_q  <= (depth_q == DW'(0));
              depth_q      <= '0;
              status_q     <= rpn_pkg::ST_OK;
            end else if (line_ok) begin
              if (is_digit) begin
                if (depth_full) begin
                  status_q <= rpn_pkg::ST_FULL;
                end else begin
                  top_q   <= {{(W - 4){1'b0}}, char_code_i[3:0]};
                  depth_q <= depth_q + DW'(1);
                end
              end else if (is_op) begin
                if (depth_ge2) begin
                  op_q    <= op_dec;
                  state_q <= S_READ;
                end else begin
                  status_q <= rpn_pkg::ST_UNDERFLOW;
                end
              end else if (char_code_i == rpn_pkg::CH_EQUALS) begin
                status_q <= rpn_pkg::ST_EQUALS;
              end else if (char_code_i != rpn_pkg::CH_SPACE) begin
                status_q <= rpn_pkg::ST_OTHER;
              end
            end
          end
        end
        S_READ: begin
          // left operand is on ram_rdata, right operand in top_q
          if (div_zero) begin
            status_q <= rpn_pkg::ST_DIVZERO;
            depth_q  <= depth_m2;
            state_q  <= depth_ge3 ? S_POP : S_IDLE;
          end else begin
            state_q <= S_ALU;
          end
        end
        S_ALU: begin
          if (alu_sts.done) begin
            top_q   <= alu_res;
            depth_q <= depth_m1;
            state_q <= S_IDLE;
          end
        end
        S_POP: begin
          top_q   <= ram_rdata;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_value_o   = out_top_q;
  assign stack_empty_o = out_empty_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_depth_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth exceeds capacity");

  a_alu_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_req.start |-> !alu_sts.busy)
    else $error("arithmetic unit started while busy");

  a_no_work_in_error : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status_q != rpn_pkg::ST_OK) |-> !alu_req.start && !ram_we)
    else $error("stack touched after a sticky error");

  a_result_from_newline : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o && is_newline))
    else $error("result produced without a newline");

  a_alu_done_expected : assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_sts.done |-> (state_q == S_ALU))
    else $error("arithmetic result arrived outside an operator");

endmodule

`default_nettype wire
